// ===== sv/ppm_pkg.sv =====
package ppm_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 8;
  localparam int unsigned CH_FIELD_W       = 3;
  localparam int unsigned NUM_CH_CODES     = 1 << CH_FIELD_W;
  localparam int unsigned LEVEL_W          = 16;
  localparam int unsigned COEF_W           = 16;
  localparam int unsigned CFG_IDX_W        = 1;

  localparam logic [LEVEL_W-1:0] FULL_SCALE  = 16'h8000;
  localparam logic [COEF_W-1:0]  ATTACK_RST  = 16'd300;
  localparam logic [COEF_W-1:0]  RELEASE_RST = 16'd2;

  localparam int unsigned WQ_DEPTH = 2;
  localparam int unsigned RQ_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 1'b0,
    REG_RELEASE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         channel;
    logic               last_of_block;
  } ppm_in_t;

  typedef struct packed {
    logic [2:0]  peak_channel;
    logic [15:0] peak_level;
  } ppm_out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]    mag;
    logic [CH_FIELD_W-1:0] channel;
    logic                  last;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t item;
  } wq_out_t;

endpackage

// ===== sv/peak_program_meter_top.sv =====
// A block's result reaches the result ports through the work queue and the result queue.
// Throughput: one beat per cycle while the result queue is not full; each channel's
// envelope is read, updated and written back in the same cycle by the envelope unit.
// Reset (rst_ni, asynchronous, active low): attack 300, release 2, all envelopes
// and block peaks zero, both queues empty.
module peak_program_meter_top #(
  parameter int unsigned MaxChannels = ppm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  ppm_pkg::ppm_in_t              in_i,
  output logic                          empty,
  input  logic                          pop,
  output ppm_pkg::ppm_out_t             out_o,
  input  logic                          cfg_we_i,
  input  logic [ppm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppm_pkg::COEF_W-1:0]    cfg_wdata_i
);
  import ppm_pkg::*;

  wq_out_t wq;
  logic    wq_pop;

  ppm_front #(
    .MaxChannels(MaxChannels)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .in_i    (in_i),
    .wq_o    (wq),
    .wq_pop_i(wq_pop)
  );

  ppm_back #(
    .MaxChannels(MaxChannels)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .wq_i       (wq),
    .wq_pop_o   (wq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_o)
  );

`ifndef SYNTH
  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_o.peak_level <= FULL_SCALE))
    else $error("peak level above full scale");

  a_channel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ({29'd0, out_o.peak_channel} < 32'(MaxChannels)))
    else $error("result for a channel without state");

  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("input queue filled without a push");
`endif

endmodule

// ===== sv/ppm_front.sv =====
module ppm_front #(
  parameter int unsigned MaxChannels = ppm_pkg::MAX_CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  ppm_pkg::ppm_in_t in_i,
  output ppm_pkg::wq_out_t wq_o,
  input  logic             wq_pop_i
);
  import ppm_pkg::*;

  localparam int unsigned WqAw = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;

  logic [WqAw:0]   cnt_q, cnt_d;
  logic [WqAw-1:0] wr_q, wr_d, rd_q, rd_d;
  work_t           mem_q [WQ_DEPTH];

  logic  accept, keep, take;
  work_t item;

  function automatic logic [LEVEL_W-1:0] magnitude(input logic signed [15:0] s);
    logic [16:0] ext;
    logic [16:0] neg;
    ext = {s[15], s};
    neg = 17'd0 - ext;
    return s[15] ? neg[LEVEL_W-1:0] : s;
  endfunction

  assign full_o = (cnt_q == (WqAw + 1)'(WQ_DEPTH));
  assign accept = push_i & ~full_o;
  // drop beats for channels that have no state
  assign keep   = accept & ({29'd0, in_i.channel} < 32'(MaxChannels));
  assign take   = wq_pop_i & (cnt_q != '0);

  always_comb begin
    item.mag     = magnitude(in_i.sample);
    item.channel = in_i.channel;
    item.last    = in_i.last_of_block;
  end

  always_comb begin
    cnt_d = cnt_q;
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (keep) begin
      wr_d = (wr_q == WqAw'(WQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (take) begin
      rd_d = (rd_q == WqAw'(WQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (keep && !take) begin
      cnt_d = cnt_q + 1'b1;
    end else if (take && !keep) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      mem_q[wr_q] <= item;
    end
  end

  assign wq_o.valid = (cnt_q != '0);
  assign wq_o.item  = mem_q[rd_q];

endmodule

// ===== sv/ppm_back.sv =====
module ppm_back #(
  parameter int unsigned MaxChannels = ppm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ppm_pkg::COEF_W-1:0]      cfg_wdata_i,
  input  ppm_pkg::wq_out_t                wq_i,
  output logic                            wq_pop_o,
  output logic                            empty_o,
  input  logic                            pop_i,
  output ppm_pkg::ppm_out_t               out_o
);
  import ppm_pkg::*;

  localparam int unsigned NumSlots = (MaxChannels < NUM_CH_CODES) ? MaxChannels
                                                                   : NUM_CH_CODES;
  localparam int unsigned SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned RqAw     = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;

  logic [COEF_W-1:0]  attack_q, release_q;
  logic [LEVEL_W-1:0] env_q  [NumSlots];
  logic [LEVEL_W-1:0] peak_q [NumSlots];

  logic [RqAw:0]   rq_cnt_q, rq_cnt_d;
  logic [RqAw-1:0] rq_wr_q, rq_wr_d, rq_rd_q, rq_rd_d;
  ppm_out_t        rq_mem_q [RQ_DEPTH];

  logic               rq_full, go, emit, rq_pop;
  logic [SlotW-1:0]   slot;
  logic [LEVEL_W-1:0] env, peak, mag, next, new_peak;
  logic               decay;
  logic [COEF_W-1:0]  coef;
  logic [16:0]        comp;
  logic [32:0]        prod_env;
  logic [31:0]        prod_mag;
  logic [17:0]        sum;
  ppm_out_t           res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RST;
      release_q <= RELEASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ATTACK:  attack_q  <= cfg_wdata_i;
        REG_RELEASE: release_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rq_full  = (rq_cnt_q == (RqAw + 1)'(RQ_DEPTH));
  assign go       = wq_i.valid & ~rq_full;
  assign wq_pop_o = go;
  assign emit     = go & wq_i.item.last;
  assign rq_pop   = pop_i & ~empty_o;

  assign slot = SlotW'(wq_i.item.channel);
  assign env  = env_q[slot];
  assign peak = peak_q[slot];
  assign mag  = wq_i.item.mag;

  // envelope above magnitude decays, otherwise attack toward magnitude
  assign decay    = (env > mag);
  assign coef     = decay ? release_q : attack_q;
  assign comp     = 17'h10000 - {1'b0, coef};
  assign prod_env = 33'(env) * 33'(comp);
  assign prod_mag = 32'(attack_q) * 32'(mag);
  assign sum      = 18'(prod_env[32:16]) + (decay ? 18'd0 : 18'(prod_mag[31:16]));
  assign next     = (sum > 18'(FULL_SCALE)) ? FULL_SCALE : sum[LEVEL_W-1:0];
  assign new_peak = (next > peak) ? next : peak;

  always_comb begin
    res.peak_channel = wq_i.item.channel;
    res.peak_level   = new_peak;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        env_q[i]  <= '0;
        peak_q[i] <= '0;
      end
    end else if (go) begin
      env_q[slot]  <= next;
      peak_q[slot] <= wq_i.item.last ? '0 : new_peak;
    end
  end

  always_comb begin
    rq_cnt_d = rq_cnt_q;
    rq_wr_d  = rq_wr_q;
    rq_rd_d  = rq_rd_q;
    if (emit) begin
      rq_wr_d = (rq_wr_q == RqAw'(RQ_DEPTH - 1)) ? '0 : rq_wr_q + 1'b1;
    end
    if (rq_pop) begin
      rq_rd_d = (rq_rd_q == RqAw'(RQ_DEPTH - 1)) ? '0 : rq_rd_q + 1'b1;
    end
    if (emit && !rq_pop) begin
      rq_cnt_d = rq_cnt_q + 1'b1;
    end else if (rq_pop && !emit) begin
      rq_cnt_d = rq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_cnt_q <= '0;
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
    end else begin
      rq_cnt_q <= rq_cnt_d;
      rq_wr_q  <= rq_wr_d;
      rq_rd_q  <= rq_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rq_mem_q[rq_wr_q] <= res;
    end
  end

  assign empty_o = (rq_cnt_q == '0);
  assign out_o   = rq_mem_q[rq_rd_q];

endmodule

// ===== tb/peak_checker.sv =====
module peak_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  ppm_pkg::ppm_in_t               in_i,
  input  logic                           empty,
  input  logic                           pop,
  input  ppm_pkg::ppm_out_t              out_o,
  input  logic                           cfg_we_i,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppm_pkg::COEF_W-1:0]     cfg_wdata_i,
  output int                             mismatch_cnt,
  output int                             reports_pending
);
  import ppm_pkg::*;

  logic [COEF_W-1:0]  attack_q;
  logic [COEF_W-1:0]  release_q;
  logic [LEVEL_W-1:0] envelope_q [MAX_CHANNELS_DEF];
  logic [LEVEL_W-1:0] block_max_q [MAX_CHANNELS_DEF];
  ppm_out_t           peak_reports_q [$];

  initial mismatch_cnt = 0;
  initial reports_pending = 0;

  // One step of the attack/release follower; each product truncated on its own.
  function automatic logic [LEVEL_W-1:0] next_envelope(logic [15:0] env, logic [15:0] mag,
                                                       logic [15:0] atk, logic [15:0] rel);
    logic [32:0] decay, rise, carry, sum;
    if (env > mag) begin
      decay = {17'd0, env} * (33'h10000 - {17'd0, rel});
      sum = decay >> 16;
    end else begin
      rise  = {17'd0, atk} * {17'd0, mag};
      carry = {17'd0, env} * (33'h10000 - {17'd0, atk});
      sum = (rise >> 16) + (carry >> 16);
    end
    if (sum > 33'h8000) sum = 33'h8000;
    return sum[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] mag, lvl;
    int unsigned ch;
    ppm_out_t want;
    if (!rst_ni) begin
      attack_q  = ATTACK_RST;
      release_q = RELEASE_RST;
      for (int i = 0; i < MAX_CHANNELS_DEF; i++) begin
        envelope_q[i]  = '0;
        block_max_q[i] = '0;
      end
      peak_reports_q.delete();
      reports_pending <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ATTACK:  attack_q  = cfg_wdata_i;
          REG_RELEASE: release_q = cfg_wdata_i;
          default: ;
        endcase
      end

      if (pop && !empty) begin
        if (peak_reports_q.size() == 0) begin
          $error("peak report with nothing pending: channel %0d level %0d",
                 out_o.peak_channel, out_o.peak_level);
          mismatch_cnt++;
        end else begin
          want = peak_reports_q.pop_front();
          if (out_o.peak_channel !== want.peak_channel) begin
            $error("peak_channel: expected %0d, got %0d", want.peak_channel,
                   out_o.peak_channel);
            mismatch_cnt++;
          end
          if (out_o.peak_level !== want.peak_level) begin
            $error("peak_level: expected %0d, got %0d", want.peak_level, out_o.peak_level);
            mismatch_cnt++;
          end
        end
      end

      if (push && !full && in_i.channel < MAX_CHANNELS_DEF) begin
        ch  = in_i.channel;
        mag = in_i.sample[15] ? (~in_i.sample + 16'd1) : in_i.sample;
        lvl = next_envelope(envelope_q[ch], mag, attack_q, release_q);
        envelope_q[ch] = lvl;
        if (lvl > block_max_q[ch]) block_max_q[ch] = lvl;
        if (in_i.last_of_block) begin
          want.peak_channel = in_i.channel;
          want.peak_level   = block_max_q[ch];
          peak_reports_q.push_back(want);
          block_max_q[ch] = '0;
        end
      end

      reports_pending <= peak_reports_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import ppm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 225;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  ppm_in_t              in_beat = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  ppm_out_t             out_beat;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  int mismatch_cnt;
  int reports_pending;
  int cycle_cnt = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  logic hold_tgl = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  always #1 clk_i = ~clk_i;

  peak_program_meter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_beat),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  peak_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_i           (in_beat),
    .empty          (empty),
    .pop            (pop),
    .out_o          (out_beat),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .mismatch_cnt   (mismatch_cnt),
    .reports_pending(reports_pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_tgl flips.
  always @(posedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic ppm_in_t make_beat(logic [15:0] smp, logic [2:0] ch, logic last);
    ppm_in_t b;
    b.sample = smp;
    b.channel = ch;
    b.last_of_block = last;
    return b;
  endfunction

  function automatic logic [15:0] random_sample();
    case ($urandom_range(7))
      0, 1, 2: return 16'($urandom_range(65535));
      3, 4:    return 16'($signed($urandom_range(1023)) - 512);
      5:       return 16'($signed($urandom_range(8191)) - 4096);
      default: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  task automatic send_beat(input ppm_in_t b);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_beat <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Hold the sender until every pending report has come out, then let
  // the pipeline settle with push held low.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (reports_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_coefs(input logic [15:0] atk, input logic [15:0] rel);
    cfg_we <= 1'b1;
    cfg_idx <= REG_ATTACK;
    cfg_wdata <= atk;
    @(posedge clk_i);
    cfg_idx <= REG_RELEASE;
    cfg_wdata <= rel;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] atk_vals [PHASES];
    logic [15:0] rel_vals [PHASES];
    logic last;

    atk_vals = '{16'hffff, 16'h0000, 16'd300, 16'h0000, 16'h8000, 16'h0001, 16'h0000, 16'd4096};
    rel_vals = '{16'hffff, 16'h0000, 16'd2, 16'h0000, 16'd1024, 16'h8000, 16'h0000, 16'd64};
    atk_vals[3] = 16'($urandom_range(65535));
    rel_vals[3] = 16'($urandom_range(65535));
    atk_vals[6] = 16'($urandom_range(65535));
    rel_vals[6] = 16'($urandom_range(65535));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients: zero input with zero envelope takes the attack branch.
    send_beat(make_beat(16'h0000, 3'd0, 1'b1));
    send_beat(make_beat(16'h7fff, 3'd7, 1'b0));
    send_beat(make_beat(16'h8000, 3'd7, 1'b1));
    send_beat(make_beat(16'hffff, 3'd1, 1'b0));
    send_beat(make_beat(16'h0001, 3'd1, 1'b1));
    send_beat(make_beat(16'h5555, 3'd2, 1'b0));
    send_beat(make_beat(16'haaaa, 3'd2, 1'b1));
    send_beat(make_beat(16'h0000, 3'd7, 1'b1));
    drain();

    // Full attack, zero release: 1000 leaves 999, then magnitude equals envelope,
    // then the envelope holds under a zero sample.
    set_coefs(16'hffff, 16'h0000);
    send_beat(make_beat(16'd1000, 3'd3, 1'b0));
    send_beat(make_beat(16'd999, 3'd3, 1'b0));
    send_beat(make_beat(16'h0000, 3'd3, 1'b1));
    send_beat(make_beat(16'h0000, 3'd3, 1'b1));
    send_beat(make_beat(16'h8000, 3'd4, 1'b0));
    send_beat(make_beat(16'h0000, 3'd4, 1'b1));
    drain();

    // No attack, maximum release: envelope carried over collapses.
    set_coefs(16'h0000, 16'hffff);
    send_beat(make_beat(16'h0000, 3'd4, 1'b0));
    send_beat(make_beat(16'h0000, 3'd3, 1'b1));
    send_beat(make_beat(16'h8000, 3'd4, 1'b1));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_coefs(atk_vals[ph], rel_vals[ph]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 83; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      if (ph == 4) hold_tgl <= ~hold_tgl;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // During the hold-off, end every block so the result side backs up.
        last = (ph == 4 && n < 80) ? 1'b1 : ($urandom_range(5) == 0);
        send_beat(make_beat(random_sample(), 3'($urandom_range(7)), last));
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ppm_pkg.sv
sv/ppm_front.sv
sv/ppm_back.sv
sv/peak_program_meter_top.sv
tb/peak_checker.sv
tb/testbench.sv
